/* design/c8ic_pkg.sv */
// Shared types, constants and opcode codes for the CHIP-8 instruction core.
`timescale 1ns / 1ps
`default_nettype none

package c8ic_pkg;

    localparam int MEM_BYTES_DEF = 4096;
    localparam int SCREEN_W      = 64;
    localparam int SCREEN_H      = 32;
    localparam int ROW_AW        = 5;

    localparam logic [11:0] PC_RESET    = 12'h200;
    localparam logic [7:0]  SOUND_RESET = 8'd60;

    // Instruction classes, taken from the top nibble of the opcode.
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SEV  = 4'h5;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNEV = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_SKP  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    // Register-to-register operations selected by the low nibble of 8XYN.
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] NN_SKP_KEY = 8'h9E;
    localparam logic [7:0] NN_BCD     = 8'h33;
    localparam logic [3:0] FLAG_REG   = 4'hF;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_ROW   = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_MWR,
        S_MRD,
        S_DRD,
        S_FHI,
        S_FLO,
        S_DEC,
        S_EXEC,
        S_FLAG,
        S_DMEM,
        S_DROWA,
        S_DWRA,
        S_DWRB,
        S_BCD0,
        S_BCD1,
        S_BCD2,
        S_DONE
    } state_t;

    typedef struct packed {
        cmd_t        command;
        logic [11:0] address;
        logic [7:0]  write_byte;
        logic [15:0] key_mask;
        logic [7:0]  random_byte;
    } in_item_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic [11:0] program_counter;
        logic [15:0] executed_opcode;
        logic        drew;
        logic        collided;
        logic        beep;
        logic        unknown_opcode;
    } out_item_t;

    typedef struct packed {
        logic       we;
        logic [3:0] waddr;
        logic [7:0] wdata;
        logic [3:0] raddr_a;
        logic [3:0] raddr_b;
    } rf_req_t;

    typedef struct packed {
        logic              we;
        logic [ROW_AW-1:0] waddr;
        logic [63:0]       wdata;
        logic [ROW_AW-1:0] raddr;
    } disp_req_t;

endpackage

`default_nettype wire

/* design/c8ic_ram.sv */
// Single-port main memory with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module c8ic_ram #(
    parameter int DEPTH = c8ic_pkg::MEM_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] ram_mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_mem[addr] <= wdata;
        end
        rdata_reg <= ram_mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/c8ic_regfile.sv */
// Sixteen data registers V0..VF as a memory with two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module c8ic_regfile (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire c8ic_pkg::rf_req_t req,
    output logic [7:0]             rdata_a,
    output logic [7:0]             rdata_b
);

    logic [7:0]  rf_mem [16];
    logic [15:0] valid_reg;
    logic        va_reg;
    logic        vb_reg;
    logic [7:0]  da_reg;
    logic [7:0]  db_reg;

    // An entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            va_reg <= valid_reg[req.raddr_a];
            vb_reg <= valid_reg[req.raddr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            rf_mem[req.waddr] <= req.wdata;
        end
        da_reg <= rf_mem[req.raddr_a];
        db_reg <= rf_mem[req.raddr_b];
    end

    assign rdata_a = va_reg ? da_reg : 8'h00;
    assign rdata_b = vb_reg ? db_reg : 8'h00;

endmodule

`default_nettype wire

/* design/c8ic_display.sv */
// Display memory of 32 rows of 64 pixels with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module c8ic_display (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire c8ic_pkg::disp_req_t req,
    output logic [63:0]              rdata
);

    logic [63:0]                   row_mem [c8ic_pkg::SCREEN_H];
    logic [c8ic_pkg::SCREEN_H-1:0] valid_reg;
    logic                          v_reg;
    logic [63:0]                   d_reg;

    // A row never written since reset reads as blank.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            v_reg     <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            v_reg <= valid_reg[req.raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            row_mem[req.waddr] <= req.wdata;
        end
        d_reg <= row_mem[req.raddr];
    end

    assign rdata = v_reg ? d_reg : 64'h0;

endmodule

`default_nettype wire

/* design/chip8_instruction_core.sv */
// Memory write, memory read and row read run one access state; S_DONE then loads the result.
// A plain step runs S_FHI, S_FLO (two fetch reads), S_DEC (register read), S_EXEC and S_DONE;
// flag ops add S_FLAG, FX33 adds S_BCD0..S_BCD2, and DXYN adds S_FLAG and, per sprite row,
// S_DMEM, S_DROWA, S_DWRA, S_DWRB (one memory read, two row updates). One transaction at a
// time; the next is taken once the result is loaded and not stalled. Reset: the sequencer clears
// memory one byte per cycle with stall high; registers, display and sound timer reset at once.
`timescale 1ns / 1ps
`default_nettype none

module chip8_instruction_core #(
    parameter int MEM_BYTES = c8ic_pkg::MEM_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire c8ic_pkg::in_item_t item,
    input  wire logic               item_valid,
    output logic                    item_stall,
    output c8ic_pkg::out_item_t     result,
    output logic                    result_valid,
    input  wire logic               result_stall
);

    localparam int MEM_AW = $clog2(MEM_BYTES);

    // Address reduction modulo the memory size; the quotient never exceeds 7.
    function automatic logic [MEM_AW-1:0] mem_slot(input logic [11:0] a);
        logic [14:0] v;
        v = {3'b000, a};
        for (int k = 2; k >= 0; k--)
        begin
            if (v >= 15'(MEM_BYTES << k))
            begin
                v = v - 15'(MEM_BYTES << k);
            end
        end
        return v[MEM_AW-1:0];
    endfunction

    c8ic_pkg::state_t    state_reg, state_next;
    logic [MEM_AW-1:0]   clr_cnt_reg;
    c8ic_pkg::in_item_t  in_reg;
    logic [11:0]         pc_reg;
    logic [11:0]         index_reg;
    logic [7:0]          sound_reg;
    logic [7:0]          hi_reg;
    logic [15:0]         op_reg;
    logic [7:0]          vx_reg;
    logic [7:0]          vy_reg;
    logic                flag_reg;
    logic                drew_reg;
    logic                unk_reg;
    logic [3:0]          row_cnt_reg;
    logic [63:0]         mask_a_reg;
    logic [63:0]         mask_b_reg;
    logic [4:0]          row_a_reg;
    logic [7:0]          rem_reg;
    c8ic_pkg::out_item_t result_reg;
    c8ic_pkg::out_item_t result_next;
    logic                result_valid_reg;

    logic                accept;
    logic                mem_we;
    logic [11:0]         mem_addr12;
    logic [MEM_AW-1:0]   mem_addr;
    logic [7:0]          mem_wdata;
    logic [7:0]          mem_rdata;
    c8ic_pkg::rf_req_t   rf_req;
    logic [7:0]          rf_a;
    logic [7:0]          rf_b;
    c8ic_pkg::disp_req_t disp_req;
    logic [63:0]         disp_rdata;

    // Execute stage decode results.
    logic [11:0]         ex_pc;
    logic                ex_we;
    logic [7:0]          ex_wdata;
    logic                ex_flag;
    logic                ex_set_i;
    logic                ex_unk;
    c8ic_pkg::state_t    ex_next;

    // Sprite placement and BCD digits.
    logic [10:0]         lin0;
    logic [127:0]        sprite_win;
    logic [15:0]         prod_h;
    logic [7:0]          dig_h;
    logic [15:0]         prod_t;
    logic [7:0]          dig_t;
    logic [7:0]          dig_o;
    logic                last_row;

    assign accept = (state_reg == c8ic_pkg::S_IDLE) && item_valid && !item_stall;
    assign item_stall = !((state_reg == c8ic_pkg::S_IDLE) &&
                          (!result_valid_reg || !result_stall));

    c8ic_ram #(
        .DEPTH (MEM_BYTES),
        .AW    (MEM_AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    c8ic_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (rf_req),
        .rdata_a (rf_a),
        .rdata_b (rf_b)
    );

    c8ic_display u_display (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (disp_req),
        .rdata (disp_rdata)
    );

    // Sprite row placement: the 8 pixels may straddle two display rows.
    assign lin0 = 11'({3'b000, vx_reg}) +
                  {5'(vy_reg[4:0] + {1'b0, row_cnt_reg}), 6'b000000};
    assign sprite_win = {mem_rdata, 120'h0} >> lin0[5:0];
    assign last_row = (4'(row_cnt_reg + 4'd1) == op_reg[3:0]);

    // Decimal digits by reciprocal multiplication, exact for 0..255.
    assign prod_h = {8'h00, vx_reg} * 16'd41;
    assign dig_h  = {4'h0, prod_h[15:12]};
    assign prod_t = {8'h00, rem_reg} * 16'd205;
    assign dig_t  = {3'b000, prod_t[15:11]};
    assign dig_o  = rem_reg - 8'(dig_t * 8'd10);

    // Instruction decode and execute, using the register values read in decode.
    always_comb
    begin
        logic [3:0]  nib;
        logic [3:0]  sub;
        logic [7:0]  nn;
        logic [11:0] nnn;
        logic [11:0] pc_inc;
        logic [11:0] pc_skip;
        logic [8:0]  sum9;
        nib     = op_reg[15:12];
        sub     = op_reg[3:0];
        nn      = op_reg[7:0];
        nnn     = op_reg[11:0];
        pc_inc  = pc_reg + 12'd2;
        pc_skip = pc_reg + 12'd4;
        sum9    = {1'b0, rf_a} + {1'b0, rf_b};
        ex_pc    = pc_inc;
        ex_we    = 1'b0;
        ex_wdata = 8'h00;
        ex_flag  = 1'b0;
        ex_set_i = 1'b0;
        ex_unk   = 1'b0;
        ex_next  = c8ic_pkg::S_DONE;
        unique case (nib)
            c8ic_pkg::OP_JP,
            c8ic_pkg::OP_CALL: ex_pc = nnn;
            c8ic_pkg::OP_SE:   ex_pc = (rf_a == nn) ? pc_skip : pc_inc;
            c8ic_pkg::OP_SNE:  ex_pc = (rf_a != nn) ? pc_skip : pc_inc;
            c8ic_pkg::OP_SEV:  ex_pc = (rf_a == rf_b) ? pc_skip : pc_inc;
            c8ic_pkg::OP_SNEV: ex_pc = (rf_a != rf_b) ? pc_skip : pc_inc;
            c8ic_pkg::OP_LD:
            begin
                ex_we    = 1'b1;
                ex_wdata = nn;
            end
            c8ic_pkg::OP_ADD:
            begin
                ex_we    = 1'b1;
                ex_wdata = rf_a + nn;
            end
            c8ic_pkg::OP_ALU:
            begin
                ex_we = 1'b1;
                unique case (sub)
                    c8ic_pkg::ALU_MOV: ex_wdata = rf_b;
                    c8ic_pkg::ALU_OR:  ex_wdata = rf_a | rf_b;
                    c8ic_pkg::ALU_AND: ex_wdata = rf_a & rf_b;
                    c8ic_pkg::ALU_XOR: ex_wdata = rf_a ^ rf_b;
                    c8ic_pkg::ALU_ADD:
                    begin
                        ex_wdata = sum9[7:0];
                        ex_flag  = sum9[8];
                        ex_next  = c8ic_pkg::S_FLAG;
                    end
                    c8ic_pkg::ALU_SUB:
                    begin
                        ex_wdata = rf_a - rf_b;
                        ex_flag  = !(rf_b > rf_a);
                        ex_next  = c8ic_pkg::S_FLAG;
                    end
                    c8ic_pkg::ALU_SHR:
                    begin
                        ex_wdata = rf_a >> 1;
                        ex_flag  = rf_a[0];
                        ex_next  = c8ic_pkg::S_FLAG;
                    end
                    c8ic_pkg::ALU_SUBN:
                    begin
                        ex_wdata = rf_b - rf_a;
                        ex_flag  = !(rf_a > rf_b);
                        ex_next  = c8ic_pkg::S_FLAG;
                    end
                    c8ic_pkg::ALU_SHL:
                    begin
                        ex_wdata = rf_a << 1;
                        ex_flag  = rf_a[7];
                        ex_next  = c8ic_pkg::S_FLAG;
                    end
                    default:
                    begin
                        ex_we  = 1'b0;
                        ex_unk = 1'b1;
                        ex_pc  = pc_reg;
                    end
                endcase
            end
            c8ic_pkg::OP_LDI:  ex_set_i = 1'b1;
            c8ic_pkg::OP_JPV0: ex_pc = nnn + {4'h0, rf_a};
            c8ic_pkg::OP_RND:
            begin
                ex_we    = 1'b1;
                ex_wdata = nn & in_reg.random_byte;
            end
            c8ic_pkg::OP_DRW:
            begin
                ex_next = (sub == 4'h0) ? c8ic_pkg::S_FLAG : c8ic_pkg::S_DMEM;
            end
            c8ic_pkg::OP_SKP:
            begin
                if (nn != c8ic_pkg::NN_SKP_KEY)
                begin
                    ex_unk = 1'b1;
                    ex_pc  = pc_reg;
                end
                else
                begin
                    // A register value above 15 names no key.
                    ex_pc = ((rf_a[7:4] == 4'h0) && in_reg.key_mask[rf_a[3:0]]) ?
                            pc_skip : pc_inc;
                end
            end
            c8ic_pkg::OP_MISC:
            begin
                if (nn != c8ic_pkg::NN_BCD)
                begin
                    ex_unk = 1'b1;
                    ex_pc  = pc_reg;
                end
                else
                begin
                    ex_next = c8ic_pkg::S_BCD0;
                end
            end
            default:
            begin
                ex_unk = 1'b1;
                ex_pc  = pc_reg;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            c8ic_pkg::S_CLEAR:
            begin
                if (clr_cnt_reg == MEM_AW'(MEM_BYTES - 1))
                begin
                    state_next = c8ic_pkg::S_IDLE;
                end
            end
            c8ic_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.command)
                        c8ic_pkg::CMD_WRITE: state_next = c8ic_pkg::S_MWR;
                        c8ic_pkg::CMD_STEP:  state_next = c8ic_pkg::S_FHI;
                        c8ic_pkg::CMD_READ:  state_next = c8ic_pkg::S_MRD;
                        c8ic_pkg::CMD_ROW:   state_next = c8ic_pkg::S_DRD;
                        default:             state_next = c8ic_pkg::S_IDLE;
                    endcase
                end
            end
            c8ic_pkg::S_MWR,
            c8ic_pkg::S_MRD,
            c8ic_pkg::S_DRD:   state_next = c8ic_pkg::S_DONE;
            c8ic_pkg::S_FHI:   state_next = c8ic_pkg::S_FLO;
            c8ic_pkg::S_FLO:   state_next = c8ic_pkg::S_DEC;
            c8ic_pkg::S_DEC:   state_next = c8ic_pkg::S_EXEC;
            c8ic_pkg::S_EXEC:  state_next = ex_next;
            c8ic_pkg::S_FLAG:  state_next = c8ic_pkg::S_DONE;
            c8ic_pkg::S_DMEM:  state_next = c8ic_pkg::S_DROWA;
            c8ic_pkg::S_DROWA: state_next = c8ic_pkg::S_DWRA;
            c8ic_pkg::S_DWRA:  state_next = c8ic_pkg::S_DWRB;
            c8ic_pkg::S_DWRB:
            begin
                state_next = last_row ? c8ic_pkg::S_FLAG : c8ic_pkg::S_DMEM;
            end
            c8ic_pkg::S_BCD0:  state_next = c8ic_pkg::S_BCD1;
            c8ic_pkg::S_BCD1:  state_next = c8ic_pkg::S_BCD2;
            c8ic_pkg::S_BCD2:  state_next = c8ic_pkg::S_DONE;
            c8ic_pkg::S_DONE:  state_next = c8ic_pkg::S_IDLE;
            default:           state_next = c8ic_pkg::S_IDLE;
        endcase
    end

    // Memory, register file and display port control per state.
    always_comb
    begin
        mem_we         = 1'b0;
        mem_addr12     = 12'h000;
        mem_wdata      = 8'h00;
        rf_req         = '0;
        disp_req       = '0;
        unique case (state_reg)
            c8ic_pkg::S_MWR:
            begin
                mem_we     = 1'b1;
                mem_addr12 = in_reg.address;
                mem_wdata  = in_reg.write_byte;
            end
            c8ic_pkg::S_MRD: mem_addr12 = in_reg.address;
            c8ic_pkg::S_DRD: disp_req.raddr = in_reg.address[4:0];
            c8ic_pkg::S_FHI: mem_addr12 = pc_reg;
            c8ic_pkg::S_FLO: mem_addr12 = pc_reg + 12'd1;
            c8ic_pkg::S_DEC:
            begin
                // BNNN reads V0 on the first port instead of VX.
                rf_req.raddr_a = (hi_reg[7:4] == c8ic_pkg::OP_JPV0) ? 4'h0 : hi_reg[3:0];
                rf_req.raddr_b = mem_rdata[7:4];
            end
            c8ic_pkg::S_EXEC:
            begin
                rf_req.we    = ex_we;
                rf_req.waddr = op_reg[11:8];
                rf_req.wdata = ex_wdata;
            end
            c8ic_pkg::S_FLAG:
            begin
                rf_req.we    = 1'b1;
                rf_req.waddr = c8ic_pkg::FLAG_REG;
                rf_req.wdata = {7'h00, flag_reg};
            end
            c8ic_pkg::S_DMEM: mem_addr12 = index_reg + {8'h00, row_cnt_reg};
            c8ic_pkg::S_DROWA: disp_req.raddr = lin0[10:6];
            c8ic_pkg::S_DWRA:
            begin
                disp_req.we    = 1'b1;
                disp_req.waddr = row_a_reg;
                disp_req.wdata = disp_rdata ^ mask_a_reg;
                disp_req.raddr = row_a_reg + 5'd1;
            end
            c8ic_pkg::S_DWRB:
            begin
                disp_req.we    = 1'b1;
                disp_req.waddr = row_a_reg + 5'd1;
                disp_req.wdata = disp_rdata ^ mask_b_reg;
            end
            c8ic_pkg::S_BCD0:
            begin
                mem_we     = 1'b1;
                mem_addr12 = index_reg;
                mem_wdata  = dig_h;
            end
            c8ic_pkg::S_BCD1:
            begin
                mem_we     = 1'b1;
                mem_addr12 = index_reg + 12'd1;
                mem_wdata  = dig_t;
            end
            c8ic_pkg::S_BCD2:
            begin
                mem_we     = 1'b1;
                mem_addr12 = index_reg + 12'd2;
                mem_wdata  = dig_o;
            end
            c8ic_pkg::S_CLEAR: mem_we = 1'b1;
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
        mem_addr = (state_reg == c8ic_pkg::S_CLEAR) ? clr_cnt_reg : mem_slot(mem_addr12);
    end

    // Result of the transaction being finished.
    always_comb
    begin
        result_next                 = '0;
        result_next.program_counter = pc_reg;
        unique case (in_reg.command)
            c8ic_pkg::CMD_READ: result_next.read_data = {56'h0, mem_rdata};
            c8ic_pkg::CMD_ROW:  result_next.read_data = disp_rdata;
            c8ic_pkg::CMD_STEP:
            begin
                result_next.executed_opcode = op_reg;
                result_next.drew            = drew_reg;
                result_next.collided        = drew_reg & flag_reg;
                result_next.beep            = (sound_reg == 8'd1);
                result_next.unknown_opcode  = unk_reg;
            end
            default:
            begin
                result_next.read_data = 64'h0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= c8ic_pkg::S_CLEAR;
            clr_cnt_reg      <= '0;
            pc_reg           <= c8ic_pkg::PC_RESET;
            index_reg        <= 12'h000;
            sound_reg        <= c8ic_pkg::SOUND_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == c8ic_pkg::S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
            end
            if (state_reg == c8ic_pkg::S_EXEC)
            begin
                pc_reg <= ex_pc;
                if (ex_set_i)
                begin
                    index_reg <= op_reg[11:0];
                end
            end
            if ((state_reg == c8ic_pkg::S_DONE) && (in_reg.command == c8ic_pkg::CMD_STEP) &&
                (sound_reg != 8'h00))
            begin
                sound_reg <= sound_reg - 8'd1;
            end
            if (state_reg == c8ic_pkg::S_DONE)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
        unique case (state_reg)
            c8ic_pkg::S_FLO: hi_reg <= mem_rdata;
            c8ic_pkg::S_DEC: op_reg <= {hi_reg, mem_rdata};
            c8ic_pkg::S_EXEC:
            begin
                vx_reg      <= rf_a;
                vy_reg      <= rf_b;
                flag_reg    <= ex_flag;
                drew_reg    <= (op_reg[15:12] == c8ic_pkg::OP_DRW);
                unk_reg     <= ex_unk;
                row_cnt_reg <= 4'h0;
            end
            c8ic_pkg::S_DROWA:
            begin
                mask_a_reg <= sprite_win[127:64];
                mask_b_reg <= sprite_win[63:0];
                row_a_reg  <= lin0[10:6];
            end
            c8ic_pkg::S_DWRA: flag_reg <= flag_reg | (|(disp_rdata & mask_a_reg));
            c8ic_pkg::S_DWRB:
            begin
                flag_reg    <= flag_reg | (|(disp_rdata & mask_b_reg));
                row_cnt_reg <= row_cnt_reg + 4'd1;
            end
            c8ic_pkg::S_BCD0: rem_reg <= vx_reg - 8'(dig_h * 8'd100);
            c8ic_pkg::S_DONE: result_reg <= result_next;
            default:
            begin
                row_cnt_reg <= row_cnt_reg;
            end
        endcase
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

/* design/c8ic_checker.sv */
// Port-level checks for the CHIP-8 instruction core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module c8ic_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_valid,
    input wire logic                item_stall,
    input wire c8ic_pkg::out_item_t result,
    input wire logic                result_valid,
    input wire logic                result_stall
);

    // A result held back by the receiver stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // The core works on one transaction at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second transaction taken while busy");

    a_collide_needs_draw: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.collided |-> result.drew && !result.unknown_opcode)
        else $error("collision reported without a sprite draw");

    // Read data only comes from read commands, which fetch no instruction.
    a_read_not_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.read_data != 64'h0) |->
            (result.executed_opcode == 16'h0000) && !result.beep && !result.drew)
        else $error("read data mixed with step status");

endmodule

bind chip8_instruction_core c8ic_checker u_c8ic_checker (.*);

`default_nettype wire
